@@ rtl/tpsm_pkg.sv @@
`timescale 1ns / 1ps
// Shared types, constants and helpers of the temporary page slot mapper.
// Used by tpsm_slot_ram, tpsm_ctrl and temp_page_slot_mapper_core.
package tpsm_pkg;

  // Slot geometry
  localparam int SLOT_COUNT = 16;
  localparam int PAGE_BYTES = 4096;
  localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
  localparam int SLOT_IW    = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int CNT_W      = $clog2(SLOT_COUNT + 1);

  localparam logic [SLOT_IW-1:0] LAST_SLOT  = SLOT_IW'(SLOT_COUNT - 1);
  localparam logic [CNT_W-1:0]   LAST_CNT   = CNT_W'(SLOT_COUNT - 1);
  localparam logic [CNT_W-1:0]   SCAN_END   = CNT_W'(SLOT_COUNT);
  localparam logic [31:0]        REGION_SPAN = 32'(SLOT_COUNT * PAGE_BYTES);

  // Page table entry addressing through the recursive window
  localparam logic [31:0] WINDOW_BASE = 32'hFFC0_0000;
  localparam int          INDEX_W     = 10;
  localparam int          DIR_SHIFT   = 22;
  localparam int          PTE_SHIFT   = 2;
  localparam logic [31:0] PRESENT_BIT = 32'h0000_0001;

  // Count saturation on the 5-bit result fields
  localparam int COUNT_MAX = 31;
  localparam int TOTAL_SAT = (SLOT_COUNT > COUNT_MAX) ? COUNT_MAX : SLOT_COUNT;

  // Configuration register indexes
  localparam logic [1:0] CFG_REGION_BASE   = 2'd0;
  localparam logic [1:0] CFG_ENABLED       = 2'd1;
  localparam logic [1:0] CFG_TABLE_PRESENT = 2'd2;

  typedef enum logic [1:0] {
    REQ_MAP   = 2'd0,
    REQ_UNMAP = 2'd1,
    REQ_STATS = 2'd2,
    REQ_NONE  = 2'd3
  } req_e;

  typedef enum logic [2:0] {
    ST_OK            = 3'd0,
    ST_NOT_ENABLED   = 3'd1,
    ST_MISALIGNED    = 3'd2,
    ST_NO_FREE       = 3'd3,
    ST_TABLE_MISSING = 3'd4,
    ST_OUTSIDE       = 3'd5,
    ST_SLOT_UNUSED   = 3'd6
  } status_e;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_PROBE,
    S_DONE
  } state_e;

  typedef struct packed {
    logic [31:0] region_base;
    logic        enabled;
    logic        table_present;
  } cfg_t;

  typedef struct packed {
    logic               we;
    logic [SLOT_IW-1:0] waddr;
    logic               wdata;
    logic               re;
    logic [SLOT_IW-1:0] raddr;
  } ram_req_t;

  typedef struct packed {
    status_e     status;
    logic [31:0] mapped_vaddr;
    logic        entry_write;
    logic [31:0] entry_address;
    logic [31:0] entry_value;
    logic [4:0]  used_count;
    logic [4:0]  slot_total;
  } res_t;

  // Entry address of a virtual address in the recursive window
  function automatic logic [31:0] pte_addr(input logic [31:0] vaddr);
    logic [INDEX_W-1:0] pd;
    logic [INDEX_W-1:0] pt;
    pd = vaddr[DIR_SHIFT +: INDEX_W];
    pt = vaddr[PAGE_SHIFT +: INDEX_W];
    return WINDOW_BASE + (32'(pd) << PAGE_SHIFT) + (32'(pt) << PTE_SHIFT);
  endfunction

  function automatic logic [4:0] sat_count(input logic [CNT_W-1:0] n);
    logic [31:0] w;
    w = 32'(n);
    return (w > 32'(COUNT_MAX)) ? 5'(COUNT_MAX) : w[4:0];
  endfunction

endpackage

@@ rtl/tpsm_slot_ram.sv @@
`timescale 1ns / 1ps
// In-use mark memory: one bit per slot, one write and one read port,
// registered read data. Depends on tpsm_pkg.
module tpsm_slot_ram (
  input  logic              clk_i,
  input  tpsm_pkg::ram_req_t req_i,
  output logic              rdata_o
);
  import tpsm_pkg::*;

  logic mem_q [SLOT_COUNT];
  logic rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr] <= req_i.wdata;
    end
  end

  // Read port, data held until the next read
  always_ff @(posedge clk_i) begin
    if (req_i.re) begin
      rdata_q <= mem_q[req_i.raddr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/tpsm_ctrl.sv @@
`timescale 1ns / 1ps
// Request sequencer: clearing pass, slot scan, unmap probe and result build,
// driving the mark memory by read-modify-write. Depends on tpsm_pkg.
module tpsm_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  tpsm_pkg::cfg_t     cfg_i,
  input  logic               clear_req_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  tpsm_pkg::req_e     req_i,
  input  logic [31:0]        page_phys_i,
  input  logic [11:0]        pte_flags_i,
  input  logic [31:0]        virt_addr_i,
  input  logic               out_free_i,
  output logic               push_o,
  output tpsm_pkg::res_t     res_o,
  output tpsm_pkg::ram_req_t ram_req_o,
  input  logic               ram_rdata_i
);
  import tpsm_pkg::*;

  state_e             state_q, state_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic               rd_vld_q;
  logic [SLOT_IW-1:0] rd_slot_q;
  req_e               req_q;
  logic [31:0]        phys_q;
  logic [11:0]        flags_q;
  logic [31:0]        virt_q;
  status_e            early_q, early_d;
  logic [SLOT_IW-1:0] slot_q;
  logic               found_q;
  logic [SLOT_IW-1:0] free_slot_q;
  logic [CNT_W-1:0]   used_q;

  logic               accept;
  logic               go_scan;
  logic               go_probe;
  logic [31:0]        offset;
  logic [31:0]        grant_vaddr;

  assign accept = (state_q == S_IDLE) && in_valid_i;
  assign offset = virt_addr_i - cfg_i.region_base;
  assign grant_vaddr = cfg_i.region_base + (32'(free_slot_q) << PAGE_SHIFT);

  // Early checks on the incoming request, in priority order
  always_comb begin
    early_d  = ST_OK;
    go_scan  = 1'b0;
    go_probe = 1'b0;
    case (req_i)
      REQ_MAP: begin
        if (!cfg_i.enabled) begin
          early_d = ST_NOT_ENABLED;
        end else if (page_phys_i[PAGE_SHIFT-1:0] != '0) begin
          early_d = ST_MISALIGNED;
        end else begin
          go_scan = 1'b1;
        end
      end
      REQ_UNMAP: begin
        if (!cfg_i.enabled) begin
          early_d = ST_NOT_ENABLED;
        end else if (offset >= REGION_SPAN) begin
          early_d = ST_OUTSIDE;
        end else begin
          go_probe = 1'b1;
        end
      end
      REQ_STATS: go_scan = 1'b1;
      default:   early_d = ST_OK;
    endcase
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_CLEAR: if (cnt_q == LAST_CNT) state_d = S_IDLE;
      S_IDLE: begin
        if (in_valid_i) begin
          if (go_scan) begin
            state_d = S_SCAN;
          end else if (go_probe) begin
            state_d = S_PROBE;
          end else begin
            state_d = S_DONE;
          end
        end
      end
      S_SCAN:  if (rd_vld_q && (rd_slot_q == LAST_SLOT)) state_d = S_DONE;
      S_PROBE: state_d = S_DONE;
      S_DONE:  if (out_free_i) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
    if (clear_req_i) begin
      state_d = S_CLEAR;
    end
  end

  // Shared clear / scan address counter
  always_comb begin
    cnt_d = '0;
    case (state_q)
      S_CLEAR: cnt_d = cnt_q + 1'b1;
      S_SCAN:  cnt_d = (cnt_q != SCAN_END) ? cnt_q + 1'b1 : cnt_q;
      default: cnt_d = '0;
    endcase
    if (clear_req_i) begin
      cnt_d = '0;
    end
  end

  // Outputs: memory port, handshake and result
  always_comb begin
    ram_req_o  = '0;
    in_stall_o = 1'b1;
    push_o     = 1'b0;
    res_o      = '0;
    res_o.status = early_q;
    unique case (state_q)
      S_CLEAR: begin
        ram_req_o.we    = 1'b1;
        ram_req_o.waddr = cnt_q[SLOT_IW-1:0];
        ram_req_o.wdata = 1'b0;
      end
      S_IDLE: in_stall_o = 1'b0;
      S_SCAN: begin
        ram_req_o.re    = (cnt_q != SCAN_END);
        ram_req_o.raddr = cnt_q[SLOT_IW-1:0];
      end
      S_PROBE: begin
        ram_req_o.re    = 1'b1;
        ram_req_o.raddr = slot_q;
      end
      S_DONE: begin
        push_o = out_free_i;
        if (early_q == ST_OK) begin
          case (req_q)
            REQ_MAP: begin
              if (!found_q) begin
                res_o.status = ST_NO_FREE;
              end else if (!cfg_i.table_present) begin
                res_o.status = ST_TABLE_MISSING;
              end else begin
                res_o.mapped_vaddr  = grant_vaddr;
                res_o.entry_write   = 1'b1;
                res_o.entry_address = pte_addr(grant_vaddr);
                res_o.entry_value   = phys_q | 32'(flags_q) | PRESENT_BIT;
                ram_req_o.we        = out_free_i;
                ram_req_o.waddr     = free_slot_q;
                ram_req_o.wdata     = 1'b1;
              end
            end
            REQ_UNMAP: begin
              if (!ram_rdata_i) begin
                res_o.status = ST_SLOT_UNUSED;
              end else begin
                if (cfg_i.table_present) begin
                  res_o.entry_write   = 1'b1;
                  res_o.entry_address = pte_addr(virt_q);
                end
                ram_req_o.we    = out_free_i;
                ram_req_o.waddr = slot_q;
                ram_req_o.wdata = 1'b0;
              end
            end
            REQ_STATS: begin
              res_o.used_count = sat_count(used_q);
              res_o.slot_total = 5'(TOTAL_SAT);
            end
            default: res_o.status = ST_OK;
          endcase
        end
      end
      default: in_stall_o = 1'b1;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_CLEAR;
      cnt_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      rd_vld_q <= (state_q == S_SCAN) && ram_req_o.re;
    end
  end

  // Request capture and scan accumulation
  always_ff @(posedge clk_i) begin
    rd_slot_q <= cnt_q[SLOT_IW-1:0];
    if (accept) begin
      req_q    <= req_i;
      phys_q   <= page_phys_i;
      flags_q  <= pte_flags_i;
      virt_q   <= virt_addr_i;
      early_q  <= early_d;
      slot_q   <= offset[PAGE_SHIFT +: SLOT_IW];
      found_q  <= 1'b0;
      used_q   <= '0;
    end else if ((state_q == S_SCAN) && rd_vld_q) begin
      if (ram_rdata_i) begin
        used_q <= used_q + 1'b1;
      end else if (!found_q) begin
        found_q     <= 1'b1;
        free_slot_q <= rd_slot_q;
      end
    end
  end

endmodule

@@ rtl/temp_page_slot_mapper_core.sv @@
`timescale 1ns / 1ps
// Top level of the temporary page slot mapper: configuration registers,
// result register, sequencer and mark memory. Depends on tpsm_pkg.
//
// Usage:
//  - Input channel (in_valid_i / in_stall_o) carries one request: map, unmap
//    or statistics. A transfer happens when valid is high and stall is low.
//  - Output channel (out_valid_o / out_stall_i) carries exactly one result
//    per request, from a result register.
//  - Configuration is a plain write port (cfg_we_i, cfg_index_i, cfg_data_i):
//    0 region base, 1 enable, 2 table present. Writing enable with 1 clears
//    all slot marks.
//  - Map and statistics scan every mark, one mark per cycle, through the
//    memory read port; unmap reads its slot mark, checks it and writes it
//    back; early rejects go straight to the result. One request is in flight
//    at a time.
//  - After reset, and after each enable write of 1, a clearing pass writes
//    every mark free; no request is taken during it.
//  - When the receiver stalls, the result register holds its result and the
//    next finished result waits in the sequencer, which takes no new request
//    until it has handed its result over. Outside the clearing pass, marks are
//    only written in that hand-over cycle, so no read can overlap a pending write.
module temp_page_slot_mapper_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  req_type_i,
  input  logic [31:0] page_phys_i,
  input  logic [11:0] pte_flags_i,
  input  logic [31:0] virt_addr_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  status_o,
  output logic [31:0] mapped_vaddr_o,
  output logic        entry_write_o,
  output logic [31:0] entry_address_o,
  output logic [31:0] entry_value_o,
  output logic [4:0]  used_count_o,
  output logic [4:0]  slot_total_o,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);
  import tpsm_pkg::*;

  cfg_t     cfg_q;
  logic     clear_req;
  logic     out_valid_q;
  res_t     out_res_q;
  logic     out_free;
  logic     push;
  res_t     res;
  ram_req_t ram_req;
  logic     ram_rdata;

  assign clear_req = cfg_we_i && (cfg_index_i == CFG_ENABLED) && cfg_data_i[0];

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.region_base   <= 32'hFE00_0000;
      cfg_q.enabled       <= 1'b0;
      cfg_q.table_present <= 1'b1;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_REGION_BASE:   cfg_q.region_base   <= cfg_data_i;
        CFG_ENABLED:       cfg_q.enabled       <= cfg_data_i[0];
        CFG_TABLE_PRESENT: cfg_q.table_present <= cfg_data_i[0];
        default:           cfg_q.enabled       <= cfg_q.enabled;
      endcase
    end
  end

  tpsm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .clear_req_i (clear_req),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .req_i       (req_e'(req_type_i)),
    .page_phys_i (page_phys_i),
    .pte_flags_i (pte_flags_i),
    .virt_addr_i (virt_addr_i),
    .out_free_i  (out_free),
    .push_o      (push),
    .res_o       (res),
    .ram_req_o   (ram_req),
    .ram_rdata_i (ram_rdata)
  );

  tpsm_slot_ram u_slot_ram (
    .clk_i   (clk_i),
    .req_i   (ram_req),
    .rdata_o (ram_rdata)
  );

  // Result register
  assign out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (push) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      out_res_q <= res;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = out_res_q.status;
  assign mapped_vaddr_o  = out_res_q.mapped_vaddr;
  assign entry_write_o   = out_res_q.entry_write;
  assign entry_address_o = out_res_q.entry_address;
  assign entry_value_o   = out_res_q.entry_value;
  assign used_count_o    = out_res_q.used_count;
  assign slot_total_o    = out_res_q.slot_total;

  // A request transfer closes the input until its result is handed over
  a_one_in_flight : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("request taken while another is in flight");

  // A clearing write of enable starts the clearing pass
  a_clear_blocks : assert property (@(posedge clk_i) disable iff (!rst_ni)
    clear_req |=> in_stall_o)
    else $error("input open during clearing pass");

  // Failed requests carry no grant and no entry
  a_fail_clean : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (status_o != ST_OK)) |->
      (mapped_vaddr_o == '0 && !entry_write_o && entry_value_o == '0))
    else $error("failed request carries payload");

  // An entry write only comes with a successful status
  a_write_ok : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && entry_write_o) |-> (status_o == ST_OK))
    else $error("entry write on failed request");

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for temp_page_slot_mapper_core: a directed table, then random
// map/unmap/statistics traffic under changing settings, checked against a local predictor.
// Depends on tpsm_pkg and the RTL of the mapper.
module tb_top;
  import tpsm_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int RAND_PHASES    = 5;
  localparam int PHASE_ITEMS    = 100;
  localparam int OFF_PHASE_ITEMS = 25;

  // One row of the directed table: a register write or a run of identical requests
  typedef struct {
    bit          is_cfg;
    logic [1:0]  cfg_idx;
    logic [31:0] cfg_val;
    int          reps;
    req_e        req;
    logic [31:0] phys;
    logic [11:0] flags;
    logic [31:0] virt;
    bit          typed;
    res_t        want;
  } step_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  req_type = REQ_NONE;
  logic [31:0] page_phys = '0;
  logic [11:0] pte_flags = '0;
  logic [31:0] virt_addr = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  status;
  logic [31:0] mapped_vaddr;
  logic        entry_write;
  logic [31:0] entry_address;
  logic [31:0] entry_value;
  logic [4:0]  used_count;
  logic [4:0]  slot_total;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;

  // Predictor copy of configuration and slot marks
  logic [31:0]           m_region_base;
  logic                  m_enabled;
  logic                  m_table_present;
  logic [SLOT_COUNT-1:0] slot_busy;

  res_t  pending_results[$];
  res_t  head_result;
  step_t directed_steps[$];

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int errors = 0;
  int items_sent = 0;
  int results_checked = 0;
  int cfg_writes = 0;
  int maps_granted = 0;
  int pool_full_hits = 0;
  int slots_freed = 0;
  int quiet_cycles = 0;

  temp_page_slot_mapper_core u_top (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .req_type_i     (req_type),
    .page_phys_i    (page_phys),
    .pte_flags_i    (pte_flags),
    .virt_addr_i    (virt_addr),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .status_o       (status),
    .mapped_vaddr_o (mapped_vaddr),
    .entry_write_o  (entry_write),
    .entry_address_o(entry_address),
    .entry_value_o  (entry_value),
    .used_count_o   (used_count),
    .slot_total_o   (slot_total),
    .cfg_we_i       (cfg_we),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data)
  );

  always #5 clk = ~clk;

  // Entry address through the recursive window: top ten bits set, then dir and table index
  function automatic logic [31:0] pte_window_addr(logic [31:0] va);
    return {10'h3FF, va[31:22], va[21:12], 2'b00};
  endfunction

  function automatic res_t result_of(status_e st, logic [31:0] va, logic ew, logic [31:0] ea,
                                     logic [31:0] ev, logic [4:0] uc, logic [4:0] ts);
    res_t r;
    r.status        = st;
    r.mapped_vaddr  = va;
    r.entry_write   = ew;
    r.entry_address = ea;
    r.entry_value   = ev;
    r.used_count    = uc;
    r.slot_total    = ts;
    return r;
  endfunction

  // Expected answer to one request; updates the slot marks
  function automatic res_t mapper_result(req_e req, logic [31:0] phys, logic [11:0] flags,
                                         logic [31:0] virt);
    res_t        r;
    int          slot;
    int          i;
    int          used;
    logic [31:0] offset;
    r = '0;
    slot = -1;
    case (req)
      REQ_MAP: begin
        for (i = SLOT_COUNT - 1; i >= 0; i--)
          if (!slot_busy[i]) slot = i;
        if (!m_enabled) r.status = ST_NOT_ENABLED;
        else if (phys[PAGE_SHIFT-1:0] != '0) r.status = ST_MISALIGNED;
        else if (slot < 0) begin
          r.status = ST_NO_FREE;
          pool_full_hits++;
        end else if (!m_table_present) r.status = ST_TABLE_MISSING;
        else begin
          slot_busy[slot] = 1'b1;
          r.mapped_vaddr  = m_region_base + 32'(slot * PAGE_BYTES);
          r.entry_write   = 1'b1;
          r.entry_address = pte_window_addr(r.mapped_vaddr);
          r.entry_value   = phys | 32'(flags) | 32'd1;
          maps_granted++;
        end
      end
      REQ_UNMAP: begin
        offset = virt - m_region_base;
        slot = int'(offset >> PAGE_SHIFT);
        if (!m_enabled) r.status = ST_NOT_ENABLED;
        else if (offset >= 32'(SLOT_COUNT * PAGE_BYTES)) r.status = ST_OUTSIDE;
        else if (!slot_busy[slot]) r.status = ST_SLOT_UNUSED;
        else begin
          slot_busy[slot] = 1'b0;
          slots_freed++;
          if (m_table_present) begin
            r.entry_write   = 1'b1;
            r.entry_address = pte_window_addr(virt);
          end
        end
      end
      REQ_STATS: begin
        used = $countones(slot_busy);
        r.used_count = 5'((used > 31) ? 31 : used);
        r.slot_total = 5'((SLOT_COUNT > 31) ? 31 : SLOT_COUNT);
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic void apply_cfg(logic [1:0] idx, logic [31:0] val);
    case (idx)
      CFG_REGION_BASE: m_region_base = val;
      CFG_ENABLED: begin
        m_enabled = val[0];
        if (val[0]) slot_busy = '0;
      end
      CFG_TABLE_PRESENT: m_table_present = val[0];
      default: ;
    endcase
  endfunction

  function automatic void cfg_row(logic [1:0] idx, logic [31:0] val);
    step_t s;
    s.is_cfg  = 1'b1;
    s.cfg_idx = idx;
    s.cfg_val = val;
    s.reps    = 1;
    s.req     = REQ_NONE;
    s.phys    = '0;
    s.flags   = '0;
    s.virt    = '0;
    s.typed   = 1'b0;
    s.want    = '0;
    directed_steps.push_back(s);
  endfunction

  function automatic void req_row(int reps, req_e req, logic [31:0] phys, logic [11:0] flags,
                                  logic [31:0] virt, bit typed, res_t want);
    step_t s;
    s.is_cfg  = 1'b0;
    s.cfg_idx = '0;
    s.cfg_val = '0;
    s.reps    = reps;
    s.req     = req;
    s.phys    = phys;
    s.flags   = flags;
    s.virt    = virt;
    s.typed   = typed;
    s.want    = want;
    directed_steps.push_back(s);
  endfunction

  // Drive one request, hold it until the transfer, then log what must come back
  task automatic send_req(req_e req, logic [31:0] phys, logic [11:0] flags, logic [31:0] virt,
                          bit typed, res_t want);
    res_t pred;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    req_type  <= req;
    page_phys <= phys;
    pte_flags <= flags;
    virt_addr <= virt;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pred = mapper_result(req, phys, flags, virt);
    pending_results.push_back(typed ? want : pred);
    items_sent++;
  endtask

  // Register write, only once the block has drained and takes requests again
  task automatic write_cfg(logic [1:0] idx, logic [31:0] val);
    in_valid <= 1'b0;
    while (pending_results.size() != 0 || in_stall) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    apply_cfg(idx, val);
    cfg_writes++;
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Mostly aligned maps and unmaps of live slots; some misaligned, stray and foreign addresses
  task automatic send_random();
    int          r;
    int          m;
    int          i;
    int          start;
    int          slot;
    logic [31:0] phys;
    logic [31:0] virt;
    logic [11:0] flags;
    req_e        req;
    phys  = $urandom;
    flags = 12'($urandom);
    virt  = $urandom;
    r = $urandom_range(99);
    if (r < 45) begin
      req = REQ_MAP;
      if ($urandom_range(9) != 0) phys[PAGE_SHIFT-1:0] = '0;
    end else if (r < 80) begin
      req = REQ_UNMAP;
      m = $urandom_range(9);
      slot = $urandom_range(SLOT_COUNT - 1);
      if (m < 6) begin
        start = slot;
        for (i = 0; i < SLOT_COUNT; i++)
          if (slot_busy[(start + i) % SLOT_COUNT]) slot = (start + i) % SLOT_COUNT;
      end
      if (m < 8)
        virt = m_region_base + 32'(slot * PAGE_BYTES) + 32'($urandom_range(PAGE_BYTES - 1));
      else if (m == 8)
        virt = $urandom_range(1) ? m_region_base + 32'(SLOT_COUNT * PAGE_BYTES)
                                 : m_region_base - 32'd1;
    end else if (r < 95) begin
      req = REQ_STATS;
    end else begin
      req = REQ_NONE;
    end
    send_req(req, phys, flags, virt, 1'b0, '0);
  endtask

  // New window, table state and enable for one random phase
  task automatic random_settings(output int n_items);
    int          pick;
    logic [31:0] base;
    pick = $urandom_range(5);
    case (pick)
      0:       base = 32'h0000_0000;
      1:       base = 32'hFFFF_FFFF;
      2:       base = 32'hFFFF_F000;
      3:       base = $urandom & 32'hFFFF_F000;
      4:       base = $urandom;
      default: base = 32'hFE00_0000;
    endcase
    write_cfg(CFG_REGION_BASE, base);
    write_cfg(CFG_TABLE_PRESENT, 32'($urandom_range(3) != 0));
    pick = $urandom_range(7);
    n_items = PHASE_ITEMS;
    if (pick == 0) begin
      write_cfg(CFG_ENABLED, 32'd0);
      n_items = OFF_PHASE_ITEMS;
    end else if (pick >= 3 || !m_enabled) begin
      write_cfg(CFG_ENABLED, 32'd1);
    end
  endtask

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch: expected 0x%0h, got 0x%0h", $time, name, want, got);
      errors++;
    end
  endtask

  // Result side: compare each transfer with the oldest expectation, stall at random
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result, status %0d, nothing pending", $time, status);
        errors++;
      end else begin
        head_result = pending_results.pop_front();
        check_field("status", 32'(head_result.status), 32'(status));
        check_field("mapped_vaddr", head_result.mapped_vaddr, mapped_vaddr);
        check_field("entry_write", 32'(head_result.entry_write), 32'(entry_write));
        check_field("entry_address", head_result.entry_address, entry_address);
        check_field("entry_value", head_result.entry_value, entry_value);
        check_field("used_count", 32'(head_result.used_count), 32'(used_count));
        check_field("slot_total", 32'(head_result.slot_total), 32'(slot_total));
        results_checked++;
      end
    end
    out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  // Watchdog: too long without any transfer on either side
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, quiet_cycles);
      $display("TEST FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int k;
    int n;
    int mode;
    int p;
    int n_items;
    m_region_base   = 32'hFE00_0000;
    m_enabled       = 1'b0;
    m_table_present = 1'b1;
    slot_busy       = '0;

    // Directed table; region at its reset value until rewritten near the end
    req_row(1, REQ_STATS, '0, '0, '0, 1'b1, result_of(ST_OK, '0, 1'b0, '0, '0, 5'd0, 5'd16));
    req_row(1, REQ_MAP, 32'h0000_1000, 12'h001, '0, 1'b1,
            result_of(ST_NOT_ENABLED, '0, 1'b0, '0, '0, '0, '0));
    req_row(1, REQ_UNMAP, '0, '0, 32'hFE00_0000, 1'b1,
            result_of(ST_NOT_ENABLED, '0, 1'b0, '0, '0, '0, '0));
    req_row(1, REQ_NONE, 32'hFFFF_FFFF, 12'hFFF, 32'hFFFF_FFFF, 1'b1,
            result_of(ST_OK, '0, 1'b0, '0, '0, '0, '0));
    cfg_row(CFG_ENABLED, 32'd1);
    req_row(1, REQ_MAP, 32'hFFFF_FFFF, 12'h000, '0, 1'b1,
            result_of(ST_MISALIGNED, '0, 1'b0, '0, '0, '0, '0));
    req_row(1, REQ_MAP, 32'hFFFF_F000, 12'hFFF, '0, 1'b1,
            result_of(ST_OK, 32'hFE00_0000, 1'b1, 32'hFFFF_8000, 32'hFFFF_FFFF, '0, '0));
    // fill the remaining slots, then one more map finds the pool full
    req_row(SLOT_COUNT - 1, REQ_MAP, 32'h0012_3000, 12'h0A5, '0, 1'b0, '0);
    req_row(1, REQ_MAP, 32'h0000_0000, 12'h000, '0, 1'b1,
            result_of(ST_NO_FREE, '0, 1'b0, '0, '0, '0, '0));
    req_row(1, REQ_STATS, '0, '0, '0, 1'b1, result_of(ST_OK, '0, 1'b0, '0, '0, 5'd16, 5'd16));
    req_row(1, REQ_UNMAP, '0, '0, 32'hFE01_0000, 1'b1,
            result_of(ST_OUTSIDE, '0, 1'b0, '0, '0, '0, '0));
    req_row(1, REQ_UNMAP, '0, '0, 32'hFDFF_FFFF, 1'b1,
            result_of(ST_OUTSIDE, '0, 1'b0, '0, '0, '0, '0));
    req_row(1, REQ_UNMAP, '0, '0, 32'hFE00_FFFF, 1'b0, '0);
    req_row(1, REQ_UNMAP, '0, '0, 32'hFE00_F000, 1'b1,
            result_of(ST_SLOT_UNUSED, '0, 1'b0, '0, '0, '0, '0));
    // missing page table: map refused, unmap frees without an entry write
    cfg_row(CFG_TABLE_PRESENT, 32'd0);
    req_row(1, REQ_MAP, 32'h0000_7000, 12'h003, '0, 1'b1,
            result_of(ST_TABLE_MISSING, '0, 1'b0, '0, '0, '0, '0));
    req_row(1, REQ_UNMAP, '0, '0, 32'hFE00_0800, 1'b1,
            result_of(ST_OK, '0, 1'b0, '0, '0, '0, '0));
    cfg_row(CFG_TABLE_PRESENT, 32'd1);
    // disabling keeps the marks
    cfg_row(CFG_ENABLED, 32'd0);
    req_row(1, REQ_STATS, '0, '0, '0, 1'b0, '0);
    // window at the top of the address space: the second slot wraps to zero
    cfg_row(CFG_REGION_BASE, 32'hFFFF_F000);
    cfg_row(CFG_ENABLED, 32'd1);
    req_row(1, REQ_MAP, 32'hFFFF_F000, 12'h000, '0, 1'b0, '0);
    req_row(1, REQ_MAP, 32'h0000_0000, 12'hFFF, '0, 1'b0, '0);
    req_row(1, REQ_UNMAP, '0, '0, 32'h0000_0FFF, 1'b0, '0);
    req_row(1, REQ_UNMAP, '0, '0, 32'hFFFF_EFFF, 1'b1,
            result_of(ST_OUTSIDE, '0, 1'b0, '0, '0, '0, '0));

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    send_idle_pct = 9;
    recv_idle_pct = 72;
    for (k = 0; k < directed_steps.size(); k++) begin
      if (directed_steps[k].is_cfg) begin
        write_cfg(directed_steps[k].cfg_idx, directed_steps[k].cfg_val);
      end else begin
        for (n = 0; n < directed_steps[k].reps; n++)
          send_req(directed_steps[k].req, directed_steps[k].phys, directed_steps[k].flags,
                   directed_steps[k].virt, directed_steps[k].typed, directed_steps[k].want);
      end
    end

    // Random traffic: sender-light idling, then receiver-light, then none
    for (mode = 0; mode < 3; mode++) begin
      case (mode)
        0: begin send_idle_pct = 9;  recv_idle_pct = 72; end
        1: begin send_idle_pct = 72; recv_idle_pct = 9;  end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      for (p = 0; p < RAND_PHASES; p++) begin
        random_settings(n_items);
        repeat (n_items) send_random();
      end
    end

    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (2 * SLOT_COUNT) @(posedge clk);

    $display("Ran %0d requests over %0d register writes; %0d results compared.",
             items_sent, cfg_writes, results_checked);
    $display("Slots granted %0d, freed %0d; pool found full %0d times.",
             maps_granted, slots_freed, pool_full_hits);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
